[rtl/obst_pkg.sv]
// Shared widths, types, controller commands and the table address function.
package obst_pkg;

    localparam int MAX_KEYS    = 64;
    localparam int WEIGHT_BITS = 12;
    localparam int DIM         = MAX_KEYS + 1;
    localparam int KEY_W       = $clog2(DIM);
    localparam int CNT_W       = $clog2(DIM + 1);
    localparam int ACC_W       = WEIGHT_BITS + KEY_W + 1;
    localparam int COST_W      = ACC_W + KEY_W;
    localparam int ADDR_W      = $clog2(DIM * DIM);

    typedef logic [WEIGHT_BITS-1:0] wgt_t;
    typedef logic [KEY_W-1:0]       key_t;
    typedef logic [CNT_W-1:0]       cnt_t;
    typedef logic [ACC_W-1:0]       acc_t;
    typedef logic [COST_W-1:0]      cost_t;
    typedef logic [ADDR_W-1:0]      addr_t;

    typedef enum logic [2:0] {
        ST_LOAD,
        ST_DIAG,
        ST_ROOT,
        ST_WINDOW,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_FINISH
    } state_t;

    typedef struct packed {
        logic accept;
        logic diag_step;
        logic root_read;
        logic window_set;
        logic scan_step;
        logic scan_drain;
        logic entry_write;
        logic result_load;
    } cmd_t;

    typedef struct packed {
        logic last_in;
        logic diag_done;
        logic n_zero;
        logic last_cand;
        logic fill_done;
        logic out_free;
    } stat_t;

    // Flat address of entry (row, col) in the square tables.
    function automatic addr_t tab_addr(input key_t row, input key_t col);
        tab_addr = addr_t'(row) * addr_t'(DIM) + addr_t'(col);
    endfunction

endpackage

[rtl/obst_ctrl.sv]
// Sequencing state machine for loading, table fill and result hand-off.
module obst_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_stall,
    input  obst_pkg::stat_t stat,
    output obst_pkg::cmd_t  cmd
);

    obst_pkg::state_t state_reg;
    obst_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= obst_pkg::ST_LOAD;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            obst_pkg::ST_LOAD:
            begin
                if (in_valid && stat.last_in)
                begin
                    state_next = obst_pkg::ST_DIAG;
                end
            end
            obst_pkg::ST_DIAG:
            begin
                if (stat.diag_done)
                begin
                    state_next = stat.n_zero ? obst_pkg::ST_FINISH : obst_pkg::ST_ROOT;
                end
            end
            obst_pkg::ST_ROOT:
            begin
                state_next = obst_pkg::ST_WINDOW;
            end
            obst_pkg::ST_WINDOW:
            begin
                state_next = obst_pkg::ST_SCAN;
            end
            obst_pkg::ST_SCAN:
            begin
                if (stat.last_cand)
                begin
                    state_next = obst_pkg::ST_DRAIN;
                end
            end
            obst_pkg::ST_DRAIN:
            begin
                state_next = obst_pkg::ST_WRITE;
            end
            obst_pkg::ST_WRITE:
            begin
                state_next = stat.fill_done ? obst_pkg::ST_FINISH : obst_pkg::ST_ROOT;
            end
            obst_pkg::ST_FINISH:
            begin
                if (stat.out_free)
                begin
                    state_next = obst_pkg::ST_LOAD;
                end
            end
            default:
            begin
                state_next = obst_pkg::ST_LOAD;
            end
        endcase
    end

    always_comb
    begin
        cmd      = '0;
        in_stall = 1'b1;
        case (state_reg)
            obst_pkg::ST_LOAD:
            begin
                in_stall   = 1'b0;
                cmd.accept = in_valid;
            end
            obst_pkg::ST_DIAG:
            begin
                cmd.diag_step = 1'b1;
            end
            obst_pkg::ST_ROOT:
            begin
                cmd.root_read = 1'b1;
            end
            obst_pkg::ST_WINDOW:
            begin
                cmd.window_set = 1'b1;
            end
            obst_pkg::ST_SCAN:
            begin
                cmd.scan_step = 1'b1;
            end
            obst_pkg::ST_DRAIN:
            begin
                cmd.scan_drain = 1'b1;
            end
            obst_pkg::ST_WRITE:
            begin
                cmd.entry_write = 1'b1;
            end
            obst_pkg::ST_FINISH:
            begin
                cmd.result_load = stat.out_free;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

endmodule

[rtl/obst_dp.sv]
// Datapath: prefix sums, cost and root tables, root window scan and result register.
module obst_dp (
    input  logic            clk,
    input  logic            rst_n,
    input  obst_pkg::cmd_t  cmd,
    output obst_pkg::stat_t stat,
    input  logic [11:0]     success_weight,
    input  logic [11:0]     failure_weight,
    input  logic            last_item,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [31:0]     min_cost,
    output logic [19:0]     total_weight,
    output logic [6:0]      root_key,
    output logic            overflow
);

    // Load side.
    obst_pkg::cnt_t  cnt_reg;
    logic            ovf_reg;
    obst_pkg::acc_t  acc_reg;
    obst_pkg::key_t  n_reg;
    logic            ovf_res_reg;
    obst_pkg::acc_t  total_reg;
    logic            fits;
    obst_pkg::wgt_t  p_eff;
    obst_pkg::wgt_t  q_in;
    obst_pkg::acc_t  b_val;
    obst_pkg::acc_t  a_val;
    obst_pkg::acc_t  acc_after;

    // Prefix stores: A[k] sums everything through gap k, B[k] = A[k] - q[k].
    obst_pkg::acc_t  pre_a_mem [obst_pkg::DIM];
    obst_pkg::acc_t  pre_b_mem [obst_pkg::DIM];
    obst_pkg::acc_t  pa_rd_reg;
    obst_pkg::acc_t  pb_rd_reg;

    // Tables.
    obst_pkg::cost_t cost_mem [obst_pkg::DIM * obst_pkg::DIM];
    obst_pkg::key_t  root_mem [obst_pkg::DIM * obst_pkg::DIM];
    obst_pkg::key_t  rlo_rd_reg;
    obst_pkg::key_t  rhi_rd_reg;
    obst_pkg::cost_t cl_rd_reg;
    obst_pkg::cost_t cr_rd_reg;

    // Fill loop.
    obst_pkg::key_t  i_reg;
    obst_pkg::key_t  len_reg;
    obst_pkg::key_t  m_reg;
    obst_pkg::key_t  end_reg;
    obst_pkg::acc_t  w_reg;
    obst_pkg::cost_t best_cost_reg;
    obst_pkg::key_t  best_m_reg;
    logic            have_reg;
    logic            pend_valid_reg;
    obst_pkg::key_t  pend_m_reg;
    obst_pkg::key_t  j;
    obst_pkg::key_t  ip1;
    obst_pkg::key_t  win_lo;
    obst_pkg::key_t  win_hi;
    obst_pkg::cost_t cand;
    logic            take;
    obst_pkg::addr_t wr_addr;
    obst_pkg::cost_t wr_cost;
    obst_pkg::key_t  wr_root;

    // Result.
    obst_pkg::cost_t res_cost_reg;
    obst_pkg::key_t  res_root_reg;
    logic            out_valid_reg;
    logic [31:0]     min_cost_reg;
    logic [19:0]     total_weight_reg;
    logic [6:0]      root_key_reg;
    logic            overflow_reg;

    always_comb
    begin
        fits      = cnt_reg < obst_pkg::cnt_t'(obst_pkg::DIM);
        p_eff     = (cnt_reg == '0) ? '0 : obst_pkg::wgt_t'(success_weight);
        q_in      = obst_pkg::wgt_t'(failure_weight);
        b_val     = acc_reg + obst_pkg::acc_t'(p_eff);
        a_val     = b_val + obst_pkg::acc_t'(q_in);
        acc_after = fits ? a_val : acc_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= '0;
            ovf_reg <= 1'b0;
            acc_reg <= '0;
        end
        else if (cmd.accept)
        begin
            if (last_item)
            begin
                cnt_reg <= '0;
                ovf_reg <= 1'b0;
                acc_reg <= '0;
            end
            else if (fits)
            begin
                cnt_reg <= cnt_reg + obst_pkg::cnt_t'(1);
                acc_reg <= a_val;
            end
            else
            begin
                ovf_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && last_item)
        begin
            n_reg       <= fits ? obst_pkg::key_t'(cnt_reg)
                                : obst_pkg::key_t'(obst_pkg::MAX_KEYS);
            ovf_res_reg <= ovf_reg | ~fits;
            total_reg   <= acc_after;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && fits)
        begin
            pre_a_mem[cnt_reg[obst_pkg::KEY_W-1:0]] <= a_val;
            pre_b_mem[cnt_reg[obst_pkg::KEY_W-1:0]] <= b_val;
        end
        if (cmd.root_read)
        begin
            pa_rd_reg <= pre_a_mem[j];
            pb_rd_reg <= pre_b_mem[i_reg];
        end
    end

    always_comb
    begin
        j       = i_reg + len_reg;
        ip1     = i_reg + obst_pkg::key_t'(1);
        win_lo  = (rlo_rd_reg < ip1) ? ip1 : rlo_rd_reg;
        win_hi  = (rhi_rd_reg > j) ? j : rhi_rd_reg;
        cand    = cl_rd_reg + cr_rd_reg;
        take    = pend_valid_reg && (!have_reg || cand < best_cost_reg);
        wr_addr = obst_pkg::tab_addr(i_reg, cmd.diag_step ? i_reg : j);
        wr_cost = cmd.diag_step ? '0 : obst_pkg::cost_t'(w_reg) + best_cost_reg;
        wr_root = cmd.diag_step ? '0 : best_m_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.diag_step || cmd.entry_write)
        begin
            cost_mem[wr_addr] <= wr_cost;
            root_mem[wr_addr] <= wr_root;
        end
        if (cmd.root_read)
        begin
            rlo_rd_reg <= root_mem[obst_pkg::tab_addr(i_reg, j - obst_pkg::key_t'(1))];
            rhi_rd_reg <= root_mem[obst_pkg::tab_addr(ip1, j)];
        end
        if (cmd.scan_step)
        begin
            cl_rd_reg <= cost_mem[obst_pkg::tab_addr(i_reg, m_reg - obst_pkg::key_t'(1))];
            cr_rd_reg <= cost_mem[obst_pkg::tab_addr(m_reg, j)];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg          <= '0;
            len_reg        <= '0;
            m_reg          <= '0;
            end_reg        <= '0;
            have_reg       <= 1'b0;
            pend_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.diag_step)
            begin
                if (stat.diag_done)
                begin
                    i_reg   <= '0;
                    len_reg <= obst_pkg::key_t'(1);
                end
                else
                begin
                    i_reg <= ip1;
                end
            end
            if (cmd.entry_write)
            begin
                if (j == n_reg)
                begin
                    i_reg   <= '0;
                    len_reg <= len_reg + obst_pkg::key_t'(1);
                end
                else
                begin
                    i_reg <= ip1;
                end
            end
            if (cmd.window_set)
            begin
                // An empty window falls back to the leftmost key as the only candidate.
                if (win_hi < win_lo)
                begin
                    m_reg   <= ip1;
                    end_reg <= ip1;
                end
                else
                begin
                    m_reg   <= win_lo;
                    end_reg <= win_hi;
                end
                have_reg       <= 1'b0;
                pend_valid_reg <= 1'b0;
            end
            if (cmd.scan_step)
            begin
                m_reg          <= m_reg + obst_pkg::key_t'(1);
                pend_valid_reg <= 1'b1;
            end
            if (cmd.scan_drain)
            begin
                pend_valid_reg <= 1'b0;
            end
            if ((cmd.scan_step || cmd.scan_drain) && take)
            begin
                have_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.window_set)
        begin
            w_reg <= pa_rd_reg - pb_rd_reg;
        end
        if (cmd.scan_step)
        begin
            pend_m_reg <= m_reg;
        end
        // Strictly smaller cost replaces, so the first minimum keeps its place.
        if ((cmd.scan_step || cmd.scan_drain) && take)
        begin
            best_cost_reg <= cand;
            best_m_reg    <= pend_m_reg;
        end
        if (cmd.diag_step || cmd.entry_write)
        begin
            res_cost_reg <= wr_cost;
            res_root_reg <= wr_root;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.result_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.result_load)
        begin
            min_cost_reg     <= 32'(res_cost_reg);
            total_weight_reg <= 20'(total_reg);
            root_key_reg     <= 7'(res_root_reg);
            overflow_reg     <= ovf_res_reg;
        end
    end

    always_comb
    begin
        stat.last_in   = last_item;
        stat.diag_done = i_reg == n_reg;
        stat.n_zero    = n_reg == '0;
        stat.last_cand = m_reg == end_reg;
        stat.fill_done = len_reg == n_reg;
        stat.out_free  = !out_valid_reg || !out_stall;
    end

    assign out_valid    = out_valid_reg;
    assign min_cost     = min_cost_reg;
    assign total_weight = total_weight_reg;
    assign root_key     = root_key_reg;
    assign overflow     = overflow_reg;

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= obst_pkg::cnt_t'(obst_pkg::DIM))
        else $error("load count ran past the store depth");

    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scan_step |-> m_reg <= end_reg)
        else $error("root scan passed the end of its window");

    a_root_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.entry_write |-> (best_m_reg > i_reg) && (best_m_reg <= j))
        else $error("chosen root lies outside its key range");

    a_set_restart: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.accept && last_item) |=> (cnt_reg == '0) && !ovf_reg)
        else $error("load state not cleared after the closing word");

endmodule

[rtl/optimal_bst_cost_top.sv]
// Top level of the optimal binary search tree cost engine.
// Words are taken one per cycle while loading; each carries a key weight and
// the following gap weight, and the word marked last closes the set of n keys
// (at most 64; further words are dropped and flagged as overflow). After the
// closing word the block stalls its input and fills the cost and root tables
// with Knuth's window: it seeds the diagonal, then for each of the n(n+1)/2
// table entries it reads the window bounds, sets the window, scans the root
// candidates in it, drains the last one and writes the entry; it then hands
// the result to the output register once the output is free. The cost table
// delivers the two subtree costs of one candidate per cycle. A result waiting
// on a stalled output does not block loading of the next set.
module optimal_bst_cost_top (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [11:0] success_weight,
    input  logic [11:0] failure_weight,
    input  logic        last_item,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [31:0] min_cost,
    output logic [19:0] total_weight,
    output logic [6:0]  root_key,
    output logic        overflow
);

    obst_pkg::cmd_t  cmd;
    obst_pkg::stat_t stat;

    obst_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .stat     (stat),
        .cmd      (cmd)
    );

    obst_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .success_weight (success_weight),
        .failure_weight (failure_weight),
        .last_item      (last_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .min_cost       (min_cost),
        .total_weight   (total_weight),
        .root_key       (root_key),
        .overflow       (overflow)
    );

endmodule

[tb/sv/tb_optimal_bst_cost_top.sv]
// Self-checking testbench for the optimal binary search tree cost engine.
module tb_optimal_bst_cost_top;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [31:0] cost;
        logic [19:0] weight;
        logic [6:0]  root;
        logic        ovf;
    } tree_result_t;

    typedef enum int {
        WM_ZERO,
        WM_MAX,
        WM_EQUAL,
        WM_TINY,
        WM_EXTREME,
        WM_FULL
    } weight_mode_t;

    class bst_cost_scoreboard;
        obst_pkg::wgt_t  key_wgt [obst_pkg::DIM];
        obst_pkg::wgt_t  gap_wgt [obst_pkg::DIM];
        longint unsigned wsum [obst_pkg::DIM][obst_pkg::DIM];
        longint unsigned cost [obst_pkg::DIM][obst_pkg::DIM];
        int unsigned     root [obst_pkg::DIM][obst_pkg::DIM];
        int unsigned     held;
        bit              dropped;
        tree_result_t    expected_trees [$];
        int              errors;
        int              sets_done;
        int              overflow_sets;

        function new();
            held          = 0;
            dropped       = 0;
            errors        = 0;
            sets_done     = 0;
            overflow_sets = 0;
        endfunction

        // Knuth's window; the first strictly cheaper candidate wins.
        function int unsigned pick_root(int unsigned i, int unsigned j);
            int unsigned     lo;
            int unsigned     hi;
            int unsigned     best;
            longint unsigned best_cost;
            longint unsigned c;
            bit              have;
            lo        = root[i][j-1];
            hi        = root[i+1][j];
            best      = i + 1;
            best_cost = 0;
            have      = 0;
            if (lo < i + 1)
                lo = i + 1;
            if (hi > j)
                hi = j;
            for (int unsigned m = lo; m <= hi; m++)
            begin
                c = cost[i][m-1] + cost[m][j];
                if (!have || c < best_cost)
                begin
                    best_cost = c;
                    best      = m;
                    have      = 1;
                end
            end
            return best;
        endfunction

        function void fill(int unsigned n);
            int unsigned     j;
            int unsigned     k;
            longint unsigned w1;
            for (int unsigned i = 0; i < n; i++)
            begin
                w1 = longint'(gap_wgt[i]) + longint'(gap_wgt[i+1]) + longint'(key_wgt[i+1]);
                wsum[i][i]   = 64'(gap_wgt[i]);
                cost[i][i]   = 0;
                root[i][i]   = 0;
                wsum[i][i+1] = w1;
                cost[i][i+1] = w1;
                root[i][i+1] = i + 1;
            end
            wsum[n][n] = 64'(gap_wgt[n]);
            cost[n][n] = 0;
            root[n][n] = 0;
            for (int unsigned m = 2; m <= n; m++)
            begin
                for (int unsigned i = 0; i + m <= n; i++)
                begin
                    j = i + m;
                    wsum[i][j] = wsum[i][j-1] + longint'(key_wgt[j]) + longint'(gap_wgt[j]);
                    k = pick_root(i, j);
                    cost[i][j] = wsum[i][j] + cost[i][k-1] + cost[k][j];
                    root[i][j] = k;
                end
            end
        endfunction

        function void note_word(obst_pkg::wgt_t p, obst_pkg::wgt_t q, logic last);
            tree_result_t t;
            int unsigned  n;
            if (held < obst_pkg::DIM)
            begin
                key_wgt[held] = (held == 0) ? '0 : p;
                gap_wgt[held] = q;
                held++;
            end
            else
                dropped = 1;
            if (last)
            begin
                n = held - 1;
                fill(n);
                t.cost   = 32'(cost[0][n]);
                t.weight = 20'(wsum[0][n]);
                t.root   = 7'(root[0][n]);
                t.ovf    = dropped;
                expected_trees.push_back(t);
                sets_done++;
                if (dropped)
                    overflow_sets++;
                held    = 0;
                dropped = 0;
            end
        endfunction

        function void check_result(logic [31:0] c, logic [19:0] w, logic [6:0] r, logic o);
            tree_result_t t;
            if (expected_trees.size() == 0)
            begin
                $error("result word with no expected tree: cost %0d weight %0d", c, w);
                errors++;
                return;
            end
            t = expected_trees.pop_front();
            if (c !== t.cost)
            begin
                $error("min_cost: expected %0d, got %0d", t.cost, c);
                errors++;
            end
            if (w !== t.weight)
            begin
                $error("total_weight: expected %0d, got %0d", t.weight, w);
                errors++;
            end
            if (r !== t.root)
            begin
                $error("root_key: expected %0d, got %0d", t.root, r);
                errors++;
            end
            if (o !== t.ovf)
            begin
                $error("overflow: expected %0d, got %0d", t.ovf, o);
                errors++;
            end
        endfunction

        function int pending();
            return expected_trees.size();
        endfunction
    endclass

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    logic [11:0] success_weight;
    logic [11:0] failure_weight;
    logic        last_item;
    logic        out_valid;
    logic        out_stall;
    logic [31:0] min_cost;
    logic [19:0] total_weight;
    logic [6:0]  root_key;
    logic        overflow;

    bst_cost_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int words_sent;

    optimal_bst_cost_top i_dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .success_weight (success_weight),
        .failure_weight (failure_weight),
        .last_item      (last_item),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .min_cost       (min_cost),
        .total_weight   (total_weight),
        .root_key       (root_key),
        .overflow       (overflow)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
                sb.note_word(success_weight, failure_weight, last_item);
            if (out_valid && !out_stall)
                sb.check_result(min_cost, total_weight, root_key, overflow);
        end
    end

    function automatic obst_pkg::wgt_t pick_weight(weight_mode_t mode);
        case (mode)
            WM_ZERO:    return '0;
            WM_MAX:     return '1;
            WM_EQUAL:   return obst_pkg::wgt_t'(7);
            WM_TINY:    return obst_pkg::wgt_t'($urandom_range(3));
            WM_EXTREME: return $urandom_range(1) ? '1 : '0;
            default:    return obst_pkg::wgt_t'($urandom_range(4095));
        endcase
    endfunction

    // Presents one word and returns at the edge that accepts it.
    task automatic send_word(obst_pkg::wgt_t p, obst_pkg::wgt_t q, logic last);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid       <= 1'b1;
        success_weight <= p;
        failure_weight <= q;
        last_item      <= last;
        do
            @(posedge clk);
        while (in_stall);
        words_sent++;
    endtask

    task automatic send_set(int unsigned words, weight_mode_t mode);
        for (int unsigned k = 0; k < words; k++)
            send_word(pick_weight(mode), pick_weight(mode), k == words - 1);
    endtask

    // One edge first so the monitor has noted the word accepted just before.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic weight_mode_t random_mode();
        int r;
        r = $urandom_range(99);
        if (r < 60)
            return WM_FULL;
        else if (r < 75)
            return WM_TINY;
        else if (r < 85)
            return WM_EXTREME;
        else if (r < 90)
            return WM_EQUAL;
        else if (r < 95)
            return WM_ZERO;
        else
            return WM_MAX;
    endfunction

    initial
    begin
        #(50_000_000);
        $display("FAIL");
        $finish;
    end

    initial
    begin
        int send_pcts [4];
        int recv_pcts [4];
        int phase_goal;
        int r;
        int unsigned words;
        send_pcts = '{0, 67, 0, 12};
        recv_pcts = '{0, 0, 67, 12};
        sb = new();
        words_sent     = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        rst_n          <= 1'b0;
        in_valid       <= 1'b0;
        success_weight <= '0;
        failure_weight <= '0;
        last_item      <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Empty key sets, all-zero and equal weights for ties, and the extremes.
        send_set(1, WM_MAX);
        send_set(1, WM_ZERO);
        send_set(2, WM_MAX);
        send_set(3, WM_ZERO);
        send_set(4, WM_EQUAL);
        send_set(3, WM_MAX);
        send_set(5, WM_FULL);
        send_set(4, WM_EXTREME);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            send_idle_pct  = send_pcts[ph];
            recv_stall_pct = recv_pcts[ph];
            phase_goal     = words_sent + 407;
            // A set at full capacity, then one whose extra words (and final word) are dropped.
            send_set(obst_pkg::DIM, random_mode());
            send_set(obst_pkg::DIM + 1 + $urandom_range(4), random_mode());
            while (words_sent < phase_goal)
            begin
                r = $urandom_range(99);
                if (r < 60)
                    words = $urandom_range(6, 1);
                else if (r < 90)
                    words = $urandom_range(16, 7);
                else
                    words = $urandom_range(32, 17);
                send_set(words, random_mode());
            end
            // Hold the sender off until every tree of this phase is back.
            wait_drained();
            repeat ($urandom_range(20, 1)) @(posedge clk);
        end

        wait_drained();
        repeat (200) @(posedge clk);
        $display("Ran %0d trees from %0d words over four idle and stall phases.",
                 sb.sets_done, words_sent);
        $display("Empty, tied, full-capacity and %0d overflowing key sets were included.",
                 sb.overflow_sets);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
